// File: hdl/landmark_face_matcher_assert.svh
// ----------------------------------------------------------------------------
// Landmark face matcher assertion macros
// Wraps concurrent assertions so that synthesis sees empty text.
// ----------------------------------------------------------------------------
`ifndef LANDMARK_FACE_MATCHER_ASSERT_SVH
`define LANDMARK_FACE_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define LFM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("landmark_face_matcher assertion failed");
// The condition must never be true outside reset.
`define LFM_NEVER(lbl, clk, rst, cond) \
  `LFM_ASSERT(lbl, clk, rst, !(cond))
`else
`define LFM_ASSERT(lbl, clk, rst, prop)
`define LFM_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: hdl/lfm_pkg.sv
// ----------------------------------------------------------------------------
// Landmark face matcher package
// Sizes, register indexes and the command and status groups shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lfm_pkg;

  localparam int MAX_POINTS     = 8;
  localparam int TEMPLATE_SLOTS = 16;
  localparam int COORD_BITS     = 12;
  localparam int FRAC_BITS      = 8;

  localparam int SIZE_BITS   = 12;
  localparam int REJ_BITS    = 16;
  localparam int TCNT_BITS   = 5;
  localparam int CFG_BITS    = 16;
  localparam int SLOT_BITS   = 4;
  localparam int PT_IDX_BITS = $clog2(MAX_POINTS);
  localparam int CNT_BITS    = $clog2(MAX_POINTS + 1);
  localparam int SCNT_BITS   = $clog2(TEMPLATE_SLOTS + 1);
  localparam int ADDR_BITS   = $clog2(TEMPLATE_SLOTS) + PT_IDX_BITS;

  // Stretch divider: (p - min) * size over the span, one quotient bit a step.
  localparam int PROD_BITS = COORD_BITS + SIZE_BITS;
  localparam int DIV_STEPS = PROD_BITS;

  // Square root: one result bit a step over the scaled squared distance.
  localparam int SQ_BITS    = 2 * SIZE_BITS + 1;
  localparam int SQRT_STEPS = (SQ_BITS + 2 * FRAC_BITS + 1) / 2;
  localparam int RAD_BITS   = 2 * SQRT_STEPS;
  localparam int DIST_BITS  = SQRT_STEPS;
  localparam int SREM_BITS  = DIST_BITS + 2;

  localparam int STEP_BITS = $clog2(DIV_STEPS + SQRT_STEPS + 1);

  // Distance sums.
  localparam int SUM_BITS  = 24;
  localparam int ACC_BITS  = DIST_BITS + CNT_BITS;
  localparam int BEST_BITS = (REJ_BITS + FRAC_BITS > SUM_BITS) ?
                             (REJ_BITS + FRAC_BITS) : SUM_BITS;

  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TARGET_WIDTH    = 2'd0,
    CFG_TARGET_HEIGHT   = 2'd1,
    CFG_REJECT_DISTANCE = 2'd2,
    CFG_TEMPLATE_COUNT  = 2'd3
  } cfg_idx_t;

  // Request opcodes.
  localparam logic OP_TEMPLATE = 1'b0;
  localparam logic OP_LIVE     = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic accept_pt;   // store the accepted point
    logic start;       // a set ended: restart the point walk
    logic axis;        // 0 for x, 1 for y
    logic mul_start;   // form the dividend and load the divider
    logic div_step;
    logic save;        // keep the stretched coordinate
    logic square;      // square the offsets from the first point
    logic root_load;
    logic root_step;
    logic dist_write;  // write the distance of the current point
    logic cmp_init;
    logic mem_rd;
    logic acc;
    logic slot_end;
    logic out_load;
    logic clear_set;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic step_last;
    logic pi_in;       // current point index lies inside the set
    logic pi_last;     // current point index is the last buffer entry
    logic slot_in;     // current slot lies below the compared count
    logic is_live;
    logic out_busy;    // result register holds a result not yet taken
  } sts_t;

endpackage

// File: hdl/lfm_ctrl.sv
// ----------------------------------------------------------------------------
// Landmark face matcher controller
// Sequences the point walk, the stretch divides, the square roots, the
// template store and the slot comparison.
// ----------------------------------------------------------------------------
`include "landmark_face_matcher_assert.svh"

module lfm_ctrl import lfm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic last_point,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_PT   = 13'b0000000000010,
    S_MUL  = 13'b0000000000100,
    S_DIV  = 13'b0000000001000,
    S_SAVE = 13'b0000000010000,
    S_SQ   = 13'b0000000100000,
    S_RLD  = 13'b0000001000000,
    S_ROOT = 13'b0000010000000,
    S_WR   = 13'b0000100000000,
    S_CHK  = 13'b0001000000000,
    S_RD   = 13'b0010000000000,
    S_ACC  = 13'b0100000000000,
    S_END  = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   axis, axis_next;
  logic   in_accept;
  logic   out_wait;

  assign in_stall  = (state != S_IDLE) || out_wait;
  assign in_accept = in_valid && !in_stall;

  // Pending live result waiting for room in the result register.
  logic out_wait_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      axis     <= 1'b0;
      out_wait <= 1'b0;
    end else begin
      state    <= state_next;
      axis     <= axis_next;
      out_wait <= out_wait_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    axis_next     = axis;
    out_wait_next = out_wait;
    cmd           = '0;
    cmd.axis      = axis;
    if (out_wait && !sts.out_busy) begin
      cmd.out_load  = 1'b1;
      cmd.clear_set = 1'b1;
      out_wait_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        cmd.accept_pt = in_accept;
        if (in_accept && last_point) begin
          cmd.start  = 1'b1;
          state_next = S_PT;
        end
      end
      S_PT: begin
        axis_next  = 1'b0;
        state_next = sts.pi_in ? S_MUL : S_WR;
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) state_next = S_SAVE;
      end
      S_SAVE: begin
        cmd.save = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_RLD;
      end
      S_RLD: begin
        cmd.root_load = 1'b1;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.step_last) state_next = S_WR;
      end
      S_WR: begin
        cmd.dist_write = 1'b1;
        if (!sts.pi_last) begin
          state_next = S_PT;
        end else if (sts.is_live) begin
          cmd.cmp_init = 1'b1;
          state_next   = S_CHK;
        end else begin
          cmd.clear_set = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_CHK: begin
        if (!sts.slot_in) begin
          out_wait_next = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = sts.pi_in ? S_RD : S_END;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_CHK;
      end
      S_END: begin
        cmd.slot_end = 1'b1;
        state_next   = S_CHK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `LFM_ASSERT(a_mid_point_stays_idle, clk, rst, (in_accept && !last_point) |=> state == S_IDLE)
  `LFM_NEVER(a_load_into_busy_output, clk, rst, cmd.out_load && sts.out_busy)
  `LFM_ASSERT(a_result_only_for_live, clk, rst, cmd.out_load |-> sts.is_live)

endmodule

// File: hdl/lfm_dpath.sv
// ----------------------------------------------------------------------------
// Landmark face matcher datapath
// Point buffer and bounds, stretch divider, square root unit, template
// memory, slot comparison and the result register.
// ----------------------------------------------------------------------------
module lfm_dpath import lfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  // Request payload.
  input  logic                  opcode,
  input  logic [SLOT_BITS-1:0]  template_slot,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  match_found,
  output logic [SLOT_BITS-1:0]  match_index,
  output logic [SUM_BITS-1:0]   match_distance
);

  // Configuration registers.
  logic [SIZE_BITS-1:0] target_width, target_height;
  logic [REJ_BITS-1:0]  reject_distance;
  logic [TCNT_BITS-1:0] template_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_width    <= SIZE_BITS'(100);
      target_height   <= SIZE_BITS'(100);
      reject_distance <= REJ_BITS'(800);
      template_count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TARGET_WIDTH:    target_width    <= cfg_data[SIZE_BITS-1:0];
        CFG_TARGET_HEIGHT:   target_height   <= cfg_data[SIZE_BITS-1:0];
        CFG_REJECT_DISTANCE: reject_distance <= cfg_data[REJ_BITS-1:0];
        CFG_TEMPLATE_COUNT:  template_count  <= cfg_data[TCNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Point buffer, set count and running bounds.
  logic [COORD_BITS-1:0] buf_x [MAX_POINTS];
  logic [COORD_BITS-1:0] buf_y [MAX_POINTS];
  logic [CNT_BITS-1:0]   count;
  logic [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
  logic                  room;

  assign room = count < CNT_BITS'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_set) begin
      count <= '0;
      min_x <= COORD_MAX;
      min_y <= COORD_MAX;
      max_x <= '0;
      max_y <= '0;
    end else if (cmd.accept_pt && room) begin
      count <= count + 1'b1;
      if (point_x < min_x) min_x <= point_x;
      if (point_x > max_x) max_x <= point_x;
      if (point_y < min_y) min_y <= point_y;
      if (point_y > max_y) max_y <= point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_pt && room) begin
      buf_x[count[PT_IDX_BITS-1:0]] <= point_x;
      buf_y[count[PT_IDX_BITS-1:0]] <= point_y;
    end
  end

  // Opcode and slot of the point that ended the set.
  logic                 set_op;
  logic [SLOT_BITS-1:0] set_slot;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      set_op   <= opcode;
      set_slot <= template_slot;
    end
  end

  // Point and slot walk counters.
  logic [CNT_BITS-1:0]  pi;
  logic [SCNT_BITS-1:0] si;
  logic [SCNT_BITS-1:0] slots;

  assign slots = (template_count > TCNT_BITS'(TEMPLATE_SLOTS)) ?
                 SCNT_BITS'(TEMPLATE_SLOTS) : SCNT_BITS'(template_count);

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.cmp_init || cmd.slot_end) begin
      pi <= '0;
    end else if (cmd.dist_write || cmd.acc) begin
      pi <= pi + 1'b1;
    end
    if (cmd.cmp_init) begin
      si <= '0;
    end else if (cmd.slot_end) begin
      si <= si + 1'b1;
    end
  end

  // Shared step counter for the divider and the root unit.
  logic [STEP_BITS-1:0] step;

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      step <= STEP_BITS'(DIV_STEPS);
    end else if (cmd.root_load) begin
      step <= STEP_BITS'(SQRT_STEPS);
    end else if (cmd.div_step || cmd.root_step) begin
      step <= step - 1'b1;
    end
  end

  // Stretch divider, restoring, one quotient bit per step.
  logic [COORD_BITS-1:0] sel_p, sel_min, sel_max;
  logic [SIZE_BITS-1:0]  sel_size;
  logic [COORD_BITS-1:0] span;
  logic                  span_zero;
  logic [PROD_BITS-1:0]  div_num;
  logic [COORD_BITS-1:0] div_rem;
  logic [COORD_BITS:0]   div_sh;
  logic                  div_ge;

  always_comb begin
    if (cmd.axis) begin
      sel_p    = buf_y[pi[PT_IDX_BITS-1:0]];
      sel_min  = min_y;
      sel_max  = max_y;
      sel_size = target_height;
    end else begin
      sel_p    = buf_x[pi[PT_IDX_BITS-1:0]];
      sel_min  = min_x;
      sel_max  = max_x;
      sel_size = target_width;
    end
    span      = sel_max - sel_min;
    span_zero = sel_max <= sel_min;
    div_sh    = {div_rem, div_num[PROD_BITS-1]};
    div_ge    = div_sh >= {1'b0, span};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      div_num <= PROD_BITS'(sel_p - sel_min) * PROD_BITS'(sel_size);
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_num <= {div_num[PROD_BITS-2:0], div_ge};
      div_rem <= div_ge ? COORD_BITS'(div_sh - {1'b0, span}) : div_sh[COORD_BITS-1:0];
    end
  end

  // Stretched coordinates of the current point and of the first point.
  logic [SIZE_BITS-1:0] qx, qy, x0, y0, q;

  assign q = span_zero ? '0 : div_num[SIZE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.save) begin
      if (cmd.axis) begin
        qy <= q;
        if (pi == '0) y0 <= q;
      end else begin
        qx <= q;
        if (pi == '0) x0 <= q;
      end
    end
  end

  // Squared offsets from the first point.
  logic [SIZE_BITS-1:0]   dx, dy;
  logic [2*SIZE_BITS-1:0] dx2, dy2;

  assign dx = (qx > x0) ? qx - x0 : x0 - qx;
  assign dy = (qy > y0) ? qy - y0 : y0 - qy;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      dx2 <= dx * dx;
      dy2 <= dy * dy;
    end
  end

  // Square root, two radicand bits and one root bit per step.
  logic [RAD_BITS-1:0]  rad;
  logic [SREM_BITS-1:0] srem, s_sh, s_trial;
  logic [DIST_BITS-1:0] root;
  logic                 s_ge;

  assign s_sh    = {srem[SREM_BITS-3:0], rad[RAD_BITS-1 -: 2]};
  assign s_trial = {root, 2'b01};
  assign s_ge    = s_sh >= s_trial;

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rad  <= RAD_BITS'({(SQ_BITS'(dx2) + SQ_BITS'(dy2)), {FRAC_BITS{2'b00}}});
      srem <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[RAD_BITS-3:0], 2'b00};
      srem <= s_ge ? s_sh - s_trial : s_sh;
      root <= {root[DIST_BITS-2:0], s_ge};
    end
  end

  // Live distances and template memory.
  logic [DIST_BITS-1:0] ldist [MAX_POINTS];
  logic [DIST_BITS-1:0] tmem  [TEMPLATE_SLOTS*MAX_POINTS];
  logic [DIST_BITS-1:0] wdist, rdata;
  logic [ADDR_BITS-1:0] waddr, raddr;

  assign wdist = sts.pi_in ? root : '0;
  assign waddr = {set_slot, pi[PT_IDX_BITS-1:0]};
  assign raddr = {si[SLOT_BITS-1:0], pi[PT_IDX_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.dist_write) begin
      ldist[pi[PT_IDX_BITS-1:0]] <= wdist;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dist_write && set_op == OP_TEMPLATE) begin
      tmem[waddr] <= wdist;
    end
    if (cmd.mem_rd) begin
      rdata <= tmem[raddr];
    end
  end

  // Slot comparison.
  logic [DIST_BITS-1:0] ld, adiff;
  logic [ACC_BITS-1:0]  acc;
  logic [SUM_BITS-1:0]  sum_sat;
  logic [BEST_BITS-1:0] best;
  logic [SLOT_BITS-1:0] best_idx;
  logic                 found;

  assign ld      = ldist[pi[PT_IDX_BITS-1:0]];
  assign adiff   = (ld > rdata) ? ld - rdata : rdata - ld;
  assign sum_sat = (acc > ACC_BITS'(SUM_MAX)) ? SUM_MAX : acc[SUM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cmp_init) begin
      acc      <= '0;
      best     <= BEST_BITS'({reject_distance, {FRAC_BITS{1'b0}}});
      best_idx <= '0;
      found    <= 1'b0;
    end else if (cmd.acc) begin
      acc <= acc + ACC_BITS'(adiff);
    end else if (cmd.slot_end) begin
      acc <= '0;
      if (BEST_BITS'(sum_sat) < best) begin
        best     <= BEST_BITS'(sum_sat);
        best_idx <= si[SLOT_BITS-1:0];
        found    <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      match_found    <= found;
      match_index    <= found ? best_idx : '0;
      match_distance <= found ? best[SUM_BITS-1:0] : '0;
    end
  end

  // Status to the controller.
  always_comb begin
    sts           = '0;
    sts.step_last = step == STEP_BITS'(1);
    sts.pi_in     = pi < count;
    sts.pi_last   = pi == CNT_BITS'(MAX_POINTS - 1);
    sts.slot_in   = si < slots;
    sts.is_live   = set_op == OP_LIVE;
    sts.out_busy  = out_valid && out_stall;
  end

endmodule

// File: hdl/landmark_face_matcher.sv
// A set's last point starts a walk over the buffer: two 24-step divides and a
// 21-step root for each point in the set, a zero distance for each unused entry;
// a live set then sums the distance differences of its points for each compared slot.
// Throughput: points that do not end a set are taken one per cycle; the walk, and
// a finished result still waiting for the output register, stall input. Synchronous
// reset clears bounds, count, result valid and control.
// ----------------------------------------------------------------------------
// Landmark face matcher
// Stretches landmark sets to the target box, keeps distances from the first
// point, stores templates and reports the closest template of a live face.
// ----------------------------------------------------------------------------
module landmark_face_matcher import lfm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [SLOT_BITS-1:0]  template_slot,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  last_point,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  match_found,
  output logic [SLOT_BITS-1:0]  match_index,
  output logic [SUM_BITS-1:0]   match_distance,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  lfm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last_point (last_point),
    .sts        (sts),
    .cmd        (cmd)
  );

  lfm_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (opcode),
    .template_slot  (template_slot),
    .point_x        (point_x),
    .point_y        (point_y),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .match_found    (match_found),
    .match_index    (match_index),
    .match_distance (match_distance)
  );

endmodule

// File: test/tb_landmark_face_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Landmark face matcher testbench
// Loads every template slot, then drives directed and random landmark sets
// under several box sizes, thresholds and slot counts. A built-in predictor
// computes each live face's expected match, and a checker compares every
// result. Random gaps sit on the point requests and random stalls on the results.
// ----------------------------------------------------------------------------
module tb_landmark_face_matcher;
  import lfm_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One expected or observed match report.
  typedef struct {
    logic                 found;
    logic [SLOT_BITS-1:0] index;
    logic [SUM_BITS-1:0]  distance;
  } match_t;

  localparam int SETTLE_CYCLES = 1500;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  opcode = OP_TEMPLATE;
  logic [SLOT_BITS-1:0]  template_slot = '0;
  coord_t                point_x = '0;
  coord_t                point_y = '0;
  logic                  last_point = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  match_found;
  logic [SLOT_BITS-1:0]  match_index;
  logic [SUM_BITS-1:0]   match_distance;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [CFG_BITS-1:0]   cfg_data = '0;

  // Predictor state: configuration, the open set and the stored templates.
  logic [SIZE_BITS-1:0]  box_w, box_h;
  logic [REJ_BITS-1:0]   reject_units;
  logic [TCNT_BITS-1:0]  slots_compared;
  coord_t                set_x [MAX_POINTS];
  coord_t                set_y [MAX_POINTS];
  int                    set_len;
  coord_t                lo_x, lo_y, hi_x, hi_y;
  longint unsigned       slot_dist [TEMPLATE_SLOTS][MAX_POINTS];

  // Points of each loaded template, kept to build close live faces.
  coord_t                tmpl_x [TEMPLATE_SLOTS][MAX_POINTS];
  coord_t                tmpl_y [TEMPLATE_SLOTS][MAX_POINTS];
  int                    tmpl_len [TEMPLATE_SLOTS];

  match_t                pending_matches[$];
  int                    error_count = 0;
  int                    items_sent = 0;
  int                    faces_checked = 0;
  int                    faces_matched = 0;
  int                    hold_left = 0;
  bit                    steady_mode = 0;

  landmark_face_matcher i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .template_slot  (template_slot),
    .point_x        (point_x),
    .point_y        (point_y),
    .last_point     (last_point),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .match_found    (match_found),
    .match_index    (match_index),
    .match_distance (match_distance),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Integer square root, truncated.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Stretch one coordinate into 0..size using the set's bounds.
  function automatic longint unsigned stretch_coord(coord_t p, coord_t lo, coord_t hi,
                                                    logic [SIZE_BITS-1:0] size);
    longint unsigned num;
    if (hi <= lo) return 0;
    num = longint'(p - lo) * longint'(size);
    return num / longint'(hi - lo);
  endfunction

  // Fixed-point distances of the open set from its first point.
  function automatic void set_distances(output longint unsigned d [MAX_POINTS]);
    longint unsigned x0, y0, x, y, dx, dy;
    x0 = stretch_coord(set_x[0], lo_x, hi_x, box_w);
    y0 = stretch_coord(set_y[0], lo_y, hi_y, box_h);
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (i < set_len) begin
        x = stretch_coord(set_x[i], lo_x, hi_x, box_w);
        y = stretch_coord(set_y[i], lo_y, hi_y, box_h);
        dx = (x > x0) ? x - x0 : x0 - x;
        dy = (y > y0) ? y - y0 : y0 - y;
        d[i] = int_sqrt((dx * dx + dy * dy) << (2 * FRAC_BITS));
      end else begin
        d[i] = 0;
      end
    end
  endfunction

  function automatic void open_new_set();
    set_len = 0;
    lo_x = COORD_MAX;
    lo_y = COORD_MAX;
    hi_x = '0;
    hi_y = '0;
  endfunction

  // Take one accepted point; a live set's end queues the expected match.
  function automatic void absorb_point(logic op, logic [SLOT_BITS-1:0] slot,
                                       coord_t x, coord_t y, logic fin);
    longint unsigned d [MAX_POINTS];
    longint unsigned best, sum, a, b;
    int              n_slots;
    match_t          m;
    if (set_len < MAX_POINTS) begin
      set_x[set_len] = x;
      set_y[set_len] = y;
      set_len++;
      if (x < lo_x) lo_x = x;
      if (x > hi_x) hi_x = x;
      if (y < lo_y) lo_y = y;
      if (y > hi_y) hi_y = y;
    end
    if (!fin) return;
    set_distances(d);
    if (op == OP_TEMPLATE) begin
      for (int i = 0; i < MAX_POINTS; i++) slot_dist[slot][i] = d[i];
      open_new_set();
      return;
    end
    n_slots = (slots_compared > TEMPLATE_SLOTS) ? TEMPLATE_SLOTS : slots_compared;
    best = longint'(reject_units) << FRAC_BITS;
    m.found = 1'b0;
    m.index = '0;
    m.distance = '0;
    for (int s = 0; s < n_slots; s++) begin
      sum = 0;
      for (int i = 0; i < set_len; i++) begin
        a = d[i];
        b = slot_dist[s][i];
        sum += (a > b) ? a - b : b - a;
      end
      if (sum > SUM_MAX) sum = SUM_MAX;
      if (sum < best) begin
        best = sum;
        m.found = 1'b1;
        m.index = s[SLOT_BITS-1:0];
        m.distance = sum[SUM_BITS-1:0];
      end
    end
    open_new_set();
    pending_matches.insert(pending_matches.size(), m);
  endfunction

  // Gap length: mostly none or short, a few long, none in steady stretches.
  function automatic int pick_gap();
    int r;
    if (steady_mode) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Result-side stall; a requested hold-off is counted down here.
  int stall_run = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= 1'b0;
      if (!steady_mode && $urandom_range(9) == 0)
        stall_run <= ($urandom_range(9) == 0) ? $urandom_range(20, 100)
                                               : $urandom_range(1, 4);
    end
  end

  // Compare each accepted result with the oldest expected match.
  always @(posedge clk) begin
    match_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        $error("result with no expected match pending");
        error_count++;
      end else begin
        want = pending_matches.pop_front();
        faces_checked++;
        if (want.found) faces_matched++;
        if (match_found !== want.found) begin
          $error("match_found: expected %0d, got %0d", want.found, match_found);
          error_count++;
        end
        if (match_index !== want.index) begin
          $error("match_index: expected %0d, got %0d", want.index, match_index);
          error_count++;
        end
        if (match_distance !== want.distance) begin
          $error("match_distance: expected %0d, got %0d", want.distance, match_distance);
          error_count++;
        end
      end
    end
  end

  // Send one point request and wait for it to be taken.
  task automatic send_point(logic op, logic [SLOT_BITS-1:0] slot, coord_t x, coord_t y,
                            logic fin);
    int gap;
    in_valid <= 1'b1;
    opcode <= op;
    template_slot <= slot;
    point_x <= x;
    point_y <= y;
    last_point <= fin;
    do @(posedge clk); while (in_stall);
    absorb_point(op, slot, x, y, fin);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected match has come.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  // Write one register once the block is idle.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TARGET_WIDTH:    box_w = value[SIZE_BITS-1:0];
      CFG_TARGET_HEIGHT:   box_h = value[SIZE_BITS-1:0];
      CFG_REJECT_DISTANCE: reject_units = value[REJ_BITS-1:0];
      CFG_TEMPLATE_COUNT:  slots_compared = value[TCNT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Send a whole set from arrays; opcode and slot of the last point decide.
  task automatic send_set(logic op, logic [SLOT_BITS-1:0] slot, coord_t xs[$], coord_t ys[$]);
    for (int i = 0; i < xs.size(); i++)
      send_point(op, slot, xs[i], ys[i], i == xs.size() - 1);
  endtask

  // A random set; clustered points most of the time, full range otherwise.
  task automatic random_set(logic op, logic [SLOT_BITS-1:0] slot);
    coord_t xs[$], ys[$];
    int     n, cx, cy, spread;
    logic   pt_op;
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, MAX_POINTS);
    spread = $urandom_range(1, 2000);
    cx = $urandom_range(4095);
    cy = $urandom_range(4095);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        xs.insert(xs.size(), coord_t'($urandom_range(4095)));
        ys.insert(ys.size(), coord_t'($urandom_range(4095)));
      end else begin
        xs.insert(xs.size(), coord_t'(cx + $urandom_range(spread)));
        ys.insert(ys.size(), coord_t'(cy + $urandom_range(spread)));
      end
    end
    if (op == OP_TEMPLATE) begin
      tmpl_len[slot] = (n > MAX_POINTS) ? MAX_POINTS : n;
      for (int i = 0; i < tmpl_len[slot]; i++) begin
        tmpl_x[slot][i] = xs[i];
        tmpl_y[slot][i] = ys[i];
      end
    end
    // The earlier points carry a junk slot and now and then the other opcode.
    for (int i = 0; i < n; i++) begin
      pt_op = (i < n - 1 && $urandom_range(7) == 0) ? ~op : op;
      send_point(pt_op, (i < n - 1) ? SLOT_BITS'($urandom) : slot, xs[i], ys[i], i == n - 1);
    end
  endtask

  // A live face built from a stored template, with optional jitter.
  task automatic face_like_template(int slot, int jitter);
    coord_t xs[$], ys[$];
    for (int i = 0; i < tmpl_len[slot]; i++) begin
      xs.insert(xs.size(), coord_t'(tmpl_x[slot][i] + $urandom_range(jitter)));
      ys.insert(ys.size(), coord_t'(tmpl_y[slot][i] + $urandom_range(jitter)));
    end
    send_set(OP_LIVE, SLOT_BITS'($urandom), xs, ys);
  endtask

  // Some live face: mostly close to a loaded template, sometimes arbitrary.
  task automatic random_face();
    if ($urandom_range(2) != 0)
      face_like_template($urandom_range(TEMPLATE_SLOTS - 1), $urandom_range(3) * 3);
    else
      random_set(OP_LIVE, SLOT_BITS'($urandom));
  endtask

  // Fill every slot, with edge-case shapes in the first few.
  task test_template_load();
    coord_t xs[$], ys[$];
    xs = '{12'd0, 12'd4095, 12'd0, 12'd4095};
    ys = '{12'd0, 12'd4095, 12'd4095, 12'd0};
    send_set(OP_TEMPLATE, 4'd0, xs, ys);
    tmpl_len[0] = 4;
    foreach (xs[i]) begin tmpl_x[0][i] = xs[i]; tmpl_y[0][i] = ys[i]; end
    // A single point gives a short template of zero distances.
    xs = '{12'd2047};
    ys = '{12'd1024};
    send_set(OP_TEMPLATE, 4'd1, xs, ys);
    tmpl_len[1] = 1;
    tmpl_x[1][0] = 12'd2047;
    tmpl_y[1][0] = 12'd1024;
    // All points equal: zero span on both axes.
    xs = '{12'd300, 12'd300, 12'd300};
    ys = '{12'd77, 12'd77, 12'd77};
    send_set(OP_TEMPLATE, 4'd2, xs, ys);
    tmpl_len[2] = 3;
    for (int i = 0; i < 3; i++) begin tmpl_x[2][i] = 12'd300; tmpl_y[2][i] = 12'd77; end
    for (int s = 3; s < TEMPLATE_SLOTS; s++) random_set(OP_TEMPLATE, s[SLOT_BITS-1:0]);
  endtask

  // Live faces for each special shape.
  task test_directed_faces();
    coord_t xs[$], ys[$];
    write_reg(CFG_TEMPLATE_COUNT, 16'd16);
    face_like_template(0, 0);
    face_like_template(1, 0);
    face_like_template(2, 0);
    // Too many points: the tail is dropped, bounds unmoved.
    xs = '{12'd10, 12'd200, 12'd30, 12'd400, 12'd50, 12'd60, 12'd70, 12'd80, 12'd4095,
           12'd0};
    ys = '{12'd5, 12'd15, 12'd250, 12'd35, 12'd45, 12'd999, 12'd65, 12'd75, 12'd0, 12'd4095};
    send_set(OP_LIVE, 4'd15, xs, ys);
    // Template points finished by a live last point count as a live face.
    send_point(OP_TEMPLATE, 4'd9, 12'd100, 12'd100, 1'b0);
    send_point(OP_TEMPLATE, 4'd9, 12'd3000, 12'd2000, 1'b0);
    send_point(OP_LIVE, 4'd9, 12'd1500, 12'd3500, 1'b1);
    random_set(OP_LIVE, 4'd0);
  endtask

  // Configuration sweep with random traffic at each setting.
  task test_config_sweep();
    logic [CFG_BITS-1:0] widths [4] = '{16'd1, 16'd4095, 16'd100, 16'd37};
    logic [CFG_BITS-1:0] heights[4] = '{16'd4095, 16'd1, 16'd100, 16'd250};
    logic [CFG_BITS-1:0] rejects[4] = '{16'd0, 16'd65535, 16'd800, 16'd120};
    logic [CFG_BITS-1:0] counts [4] = '{16'd1, 16'd31, 16'd0, 16'd16};
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_TARGET_WIDTH, widths[k]);
      write_reg(CFG_TARGET_HEIGHT, heights[k]);
      write_reg(CFG_REJECT_DISTANCE, rejects[k]);
      write_reg(CFG_TEMPLATE_COUNT, counts[k]);
      for (int s = 0; s < TEMPLATE_SLOTS; s++)
        if ($urandom_range(3) == 0) random_set(OP_TEMPLATE, s[SLOT_BITS-1:0]);
      repeat (6) random_face();
    end
  endtask

  // Bulk random traffic, mostly faces, some template reloads.
  task test_random_traffic();
    int target;
    target = items_sent + 800;
    while (items_sent < target) begin
      steady_mode = ($urandom_range(7) == 0);
      if ($urandom_range(4) == 0)
        random_set(OP_TEMPLATE, SLOT_BITS'($urandom));
      else
        random_face();
    end
    steady_mode = 0;
    drain();
    write_reg(CFG_TEMPLATE_COUNT, SLOT_BITS'($urandom_range(1, 15)));
    write_reg(CFG_REJECT_DISTANCE, 16'($urandom_range(200, 3000)));
    repeat (20) random_face();
  endtask

  // Hold results back while faces keep coming, then a full drain.
  task test_backpressure();
    drain();
    hold_left = 3000;
    repeat (6) random_face();
    drain();
    repeat (4) random_face();
  endtask

  initial begin
    for (int s = 0; s < TEMPLATE_SLOTS; s++) begin
      tmpl_len[s] = 0;
      for (int i = 0; i < MAX_POINTS; i++) slot_dist[s][i] = 0;
    end
    box_w = 12'd100;
    box_h = 12'd100;
    reject_units = 16'd800;
    slots_compared = '0;
    open_new_set();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_template_load();
    test_directed_faces();
    test_config_sweep();
    test_random_traffic();
    test_backpressure();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d landmark points; checked %0d live faces, %0d of them matched.",
             items_sent, faces_checked, faces_matched);
    if (error_count == 0 && pending_matches.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
